/* src/ocvl_pkg.sv */
// Package: shared types, constants and state codes for the obstacle centroid velocity limiter.
package ocvl_pkg;

   localparam int MaxPointsDefault = 4096;
   localparam int CoordWidth = 20;
   localparam int VelWidth = 16;
   localparam int DistWidth = 14;
   localparam int SumWidth = 32;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 14;

   localparam logic [CsrIndexWidth-1:0] CSR_OBSTACLE_DISTANCE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SELF_DETECT_MARGIN = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_IGNORE_FRONT = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_HALF_LENGTH = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_HALF_WIDTH = 3'd4;

   // Square of 0.01 m threshold: cn * 10000 > 2^24.
   localparam longint SeenScale = 10000;
   localparam longint SeenLimit = 64'sd16777216;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_NORM,
      ST_DOT,
      ST_SQRT,
      ST_FDIV,
      ST_PDIV,
      ST_APPLY,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start_div;   // divide sums by tally
      logic do_norm;     // clamp, offset and seen test
      logic do_dot;      // dot product and |d|^2
      logic start_sqrt;
      logic start_fdiv;
      logic start_pdiv;
      logic do_apply;
      logic load_out;
      logic clear_acc;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic seen;
      logic dot_pos;
      logic sqrt_done;
      logic f_direct;    // factor known without division
      logic fdiv_done;
      logic pdiv_done;
   } status_type;

endpackage

/* src/ocvl_if.sv */
// Interfaces: request and response channels.
interface ocvl_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic signed [19:0] point_x;
   logic signed [19:0] point_y;
   logic signed [19:0] point_z;
   logic signed [15:0] want_lin_x;
   logic signed [15:0] want_lin_y;
   logic signed [15:0] want_lin_z;
   logic signed [15:0] want_ang_x;
   logic signed [15:0] want_ang_y;
   logic signed [15:0] want_ang_z;
   modport source (output valid, cmd, point_x, point_y, point_z, want_lin_x, want_lin_y,
                   want_lin_z, want_ang_x, want_ang_y, want_ang_z, input ready);
   modport sink (input valid, cmd, point_x, point_y, point_z, want_lin_x, want_lin_y,
                 want_lin_z, want_ang_x, want_ang_y, want_ang_z, output ready);
endinterface

interface ocvl_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] out_lin_x;
   logic signed [15:0] out_lin_y;
   logic signed [15:0] out_lin_z;
   logic signed [15:0] out_ang_x;
   logic signed [15:0] out_ang_y;
   logic signed [15:0] out_ang_z;
   logic signed [19:0] centroid_x;
   logic signed [19:0] centroid_y;
   logic signed [19:0] centroid_z;
   logic obstacle_seen;
   logic [12:0] hit_count;
   modport source (output valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
                   out_ang_z, centroid_x, centroid_y, centroid_z, obstacle_seen, hit_count,
                   input ready);
   modport sink (input valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
                 out_ang_z, centroid_x, centroid_y, centroid_z, obstacle_seen, hit_count,
                 output ready);
endinterface

/* src/ocvl_divider.sv */
// Module: iterative unsigned restoring divider, one quotient bit per cycle.
module ocvl_divider #(
   parameter int NumWidth = 64,
   parameter int DenWidth = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NumWidth-1:0] numer,
   input  logic [DenWidth-1:0] denom,
   output logic                done,
   output logic [NumWidth-1:0] quot,
   output logic [DenWidth-1:0] remain
);
   localparam int CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] quot_ff, quot_in;
   logic [DenWidth:0]   rem_ff, rem_in;
   logic [DenWidth-1:0] den_ff, den_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DenWidth:0]   trial;

   // Shift in one numerator bit and try the subtract.
   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[DenWidth-1:0], quot_ff[NumWidth-1]};
      if (start) begin
         quot_in = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = CntWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign remain = rem_ff[DenWidth-1:0];
endmodule

/* src/ocvl_sqrt.sv */
// Module: iterative integer square root, two radicand bits per cycle.
module ocvl_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] val_ff, val_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] res_ff, res_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;
   logic [33:0] cand;

   // Bring down two bits, compare against 4*res+1.
   always_comb begin
      val_in = val_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[31:0], val_ff[63:62]};
      cand = {res_ff, 2'b01};
      if (start) begin
         val_in = radicand;
         rem_in = '0;
         res_in = '0;
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[61:0], 2'b00};
         if (trial >= cand) begin
            rem_in = trial - cand;
            res_in = {res_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            res_in = {res_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      val_ff <= val_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign root = res_ff;
endmodule

/* src/ocvl_ctrl.sv */
// Module: sequencer for the end-of-scan computation.
module ocvl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  end_take,
   input  logic                  rsp_take,
   input  ocvl_pkg::status_type  status,
   output ocvl_pkg::cmd_type     cmd,
   output logic                  busy,
   output logic                  rsp_valid
);
   import ocvl_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (end_take) begin
               cmd.start_div = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.do_norm = 1'b1;
            state_in = ST_DOT;
         end
         ST_DOT: begin
            if (!status.seen) begin
               cmd.load_out = 1'b1;
               state_in = ST_OUT;
            end else begin
               cmd.do_dot = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (!status.dot_pos) begin
               cmd.load_out = 1'b1;
               state_in = ST_OUT;
            end else begin
               cmd.start_sqrt = 1'b1;
               cmd.start_pdiv = 1'b1;
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            if (status.sqrt_done) begin
               if (status.f_direct) begin
                  state_in = ST_PDIV;
               end else begin
                  cmd.start_fdiv = 1'b1;
                  state_in = ST_PDIV;
               end
            end
         end
         ST_PDIV: begin
            if (status.pdiv_done && status.fdiv_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.do_apply = 1'b1;
            cmd.load_out = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_take) begin
               cmd.clear_acc = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

/* src/ocvl_datapath.sv */
// Module: point gating, accumulators and end-of-scan arithmetic.
module ocvl_datapath #(
   parameter int MaxPoints = ocvl_pkg::MaxPointsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 point_take,
   input  logic                 end_take,
   input  ocvl_pkg::cmd_type    cmd,
   output ocvl_pkg::status_type status,
   input  logic [13:0]          obstacle_distance,
   input  logic [13:0]          self_detect_margin,
   input  logic                 ignore_front,
   input  logic [13:0]          half_length,
   input  logic [13:0]          half_width,
   input  logic signed [19:0]   point_x,
   input  logic signed [19:0]   point_y,
   input  logic signed [19:0]   point_z,
   input  logic signed [15:0]   want_lin_x,
   input  logic signed [15:0]   want_lin_y,
   input  logic signed [15:0]   want_lin_z,
   input  logic signed [15:0]   want_ang_x,
   input  logic signed [15:0]   want_ang_y,
   input  logic signed [15:0]   want_ang_z,
   output logic signed [15:0]   out_lin_x,
   output logic signed [15:0]   out_lin_y,
   output logic signed [15:0]   out_lin_z,
   output logic signed [15:0]   out_ang_x,
   output logic signed [15:0]   out_ang_y,
   output logic signed [15:0]   out_ang_z,
   output logic signed [19:0]   centroid_x,
   output logic signed [19:0]   centroid_y,
   output logic signed [19:0]   centroid_z,
   output logic                 obstacle_seen,
   output logic [12:0]          hit_count
);
   import ocvl_pkg::*;

   localparam int TallyWidth = $clog2(MaxPoints + 1);

   // ---------------- point gating and accumulation ----------------
   logic signed [SumWidth-1:0] sum_x_ff, sum_y_ff, sum_z_ff;
   logic [TallyWidth-1:0]      tally_ff;
   logic [19:0]                ax, ay;
   logic [14:0]                lim_xo, lim_yo, lim_xi, lim_yi;
   logic                       hit;

   always_comb begin
      ax = point_x[19] ? 20'(-point_x) : 20'(point_x);
      ay = point_y[19] ? 20'(-point_y) : 20'(point_y);
      lim_xo = {1'b0, half_length} + {1'b0, obstacle_distance};
      lim_yo = {1'b0, half_width} + {1'b0, obstacle_distance};
      lim_xi = {1'b0, half_length} + {1'b0, self_detect_margin};
      lim_yi = {1'b0, half_width} + {1'b0, self_detect_margin};
      hit = (ax < 20'(lim_xo)) && (ay < 20'(lim_yo)) &&
            ((ax > 20'(lim_xi)) || (ay > 20'(lim_yi))) &&
            (!ignore_front || (point_x < $signed({6'd0, half_length})));
   end

   // Add obstacle points until the tally is full; clear after the result transfer.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_acc) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
         tally_ff <= '0;
      end else if (point_take && hit && (tally_ff < TallyWidth'(MaxPoints))) begin
         sum_x_ff <= sum_x_ff + SumWidth'(point_x);
         sum_y_ff <= sum_y_ff + SumWidth'(point_y);
         sum_z_ff <= sum_z_ff + SumWidth'(point_z);
         tally_ff <= tally_ff + 1'b1;
      end
   end

   // ---------------- end item capture ----------------
   logic signed [15:0] vx_ff, vy_ff, vz_ff, wx_ff, wy_ff, wz_ff;
   always_ff @(posedge clock) begin
      if (end_take) begin
         vx_ff <= want_lin_x;
         vy_ff <= want_lin_y;
         vz_ff <= want_lin_z;
         wx_ff <= want_ang_x;
         wy_ff <= want_ang_y;
         wz_ff <= want_ang_z;
      end
   end

   // ---------------- centroid: three dividers in parallel ----------------
   logic [31:0] mag_x, mag_y, mag_z;
   logic [31:0] qx, qy, qz;
   logic [TallyWidth-1:0] rx, ry, rz;
   logic dx_done, dy_done, dz_done;
   logic [TallyWidth-1:0] div_den;

   assign mag_x = sum_x_ff[31] ? 32'(-sum_x_ff) : 32'(sum_x_ff);
   assign mag_y = sum_y_ff[31] ? 32'(-sum_y_ff) : 32'(sum_y_ff);
   assign mag_z = sum_z_ff[31] ? 32'(-sum_z_ff) : 32'(sum_z_ff);
   assign div_den = (tally_ff == '0) ? TallyWidth'(1) : tally_ff;

   ocvl_divider #(.NumWidth(32), .DenWidth(TallyWidth)) u_div_cx (
      .clock, .reset, .start(cmd.start_div), .numer(mag_x), .denom(div_den),
      .done(dx_done), .quot(qx), .remain(rx));
   ocvl_divider #(.NumWidth(32), .DenWidth(TallyWidth)) u_div_cy (
      .clock, .reset, .start(cmd.start_div), .numer(mag_y), .denom(div_den),
      .done(dy_done), .quot(qy), .remain(ry));
   ocvl_divider #(.NumWidth(32), .DenWidth(TallyWidth)) u_div_cz (
      .clock, .reset, .start(cmd.start_div), .numer(mag_z), .denom(div_den),
      .done(dz_done), .quot(qz), .remain(rz));

   // Round half away from zero: bump when 2*rem >= den.
   function automatic logic signed [19:0] round_q(input logic [31:0] q,
                                                  input logic [TallyWidth-1:0] r,
                                                  input logic [TallyWidth-1:0] d,
                                                  input logic neg, input logic none);
      logic [32:0] m;
      logic [TallyWidth:0] r2;
      r2 = {r, 1'b0};
      m = {1'b0, q} + ((r2 >= {1'b0, d}) ? 33'd1 : 33'd0);
      if (none) begin
         return '0;
      end
      return neg ? 20'(-m) : 20'(m);
   endfunction

   logic signed [19:0] cx_ff, cy_ff, cz_ff;
   logic               div_done_ff;
   always_ff @(posedge clock) begin
      if (reset || cmd.start_div) begin
         div_done_ff <= 1'b0;
      end else if (dx_done) begin
         div_done_ff <= 1'b1;
      end
      if (dx_done) begin
         cx_ff <= round_q(qx, rx, div_den, sum_x_ff[31], tally_ff == '0);
         cy_ff <= round_q(qy, ry, div_den, sum_y_ff[31], tally_ff == '0);
         cz_ff <= round_q(qz, rz, div_den, sum_z_ff[31], tally_ff == '0);
      end
   end

   // ---------------- seen test, clamp and offset ----------------
   logic [41:0] cn;
   logic signed [20:0] ddx_c, ddy_c;
   logic signed [20:0] clx, cly;
   logic [19:0] acx, acy;
   logic seen_ff;
   logic signed [20:0] ddx_ff, ddy_ff;

   always_comb begin
      cn = 42'(cx_ff * cx_ff) + 42'(cy_ff * cy_ff) + 42'(cz_ff * cz_ff);
      acx = cx_ff[19] ? 20'(-cx_ff) : 20'(cx_ff);
      acy = cy_ff[19] ? 20'(-cy_ff) : 20'(cy_ff);
      clx = (acx > {6'd0, half_length}) ? 21'({7'd0, half_length}) : 21'({1'b0, acx});
      cly = (acy > {6'd0, half_width}) ? 21'({7'd0, half_width}) : 21'({1'b0, acy});
      ddx_c = 21'(cx_ff) - (cx_ff[19] ? -clx : clx);
      ddy_c = 21'(cy_ff) - (cy_ff[19] ? -cly : cly);
   end

   // 10000*cn > 2^24 is cn > 1677 (integer cn).
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (cmd.do_norm) begin
         seen_ff <= (cn > 42'd1677);
      end
      if (cmd.do_norm) begin
         ddx_ff <= ddx_c;
         ddy_ff <= ddy_c;
      end
   end

   // ---------------- dot product and squared offset ----------------
   logic signed [38:0] dot_ff;
   logic [41:0]        sq_ff;
   logic               dot_pos_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_pos_ff <= 1'b0;
      end else if (cmd.do_dot) begin
         dot_pos_ff <= (39'(vx_ff * ddx_ff) + 39'(vy_ff * ddy_ff)) > 39'sd0;
      end
      if (cmd.do_dot) begin
         dot_ff <= 39'(vx_ff * ddx_ff) + 39'(vy_ff * ddy_ff);
         sq_ff <= 42'(ddx_ff * ddx_ff) + 42'(ddy_ff * ddy_ff);
      end
   end

   // ---------------- square root and factor ----------------
   logic        sqrt_done;
   logic [31:0] root;
   ocvl_sqrt u_sqrt (.clock, .reset, .start(cmd.start_sqrt), .radicand({6'd0, sq_ff, 16'd0}),
                     .done(sqrt_done), .root(root));

   logic [21:0] odr;
   logic        f_direct;
   logic [16:0] f_direct_val;
   always_comb begin
      odr = {obstacle_distance, 8'd0};
      f_direct = 1'b1;
      f_direct_val = 17'd65536;
      if (obstacle_distance == '0) begin
         f_direct_val = 17'd65536;
      end else if (root >= {10'd0, odr}) begin
         f_direct_val = '0;
      end else if ({root, 1'b0} <= {11'd0, odr}) begin
         f_direct_val = 17'd65536;
      end else begin
         f_direct = 1'b0;
      end
   end

   logic        fdiv_done;
   logic [63:0] fq;
   logic [21:0] fr;
   logic [63:0] f_num;
   assign f_num = {25'd0, 22'(odr - root[21:0]), 17'd0};
   ocvl_divider #(.NumWidth(64), .DenWidth(22)) u_div_f (
      .clock, .reset, .start(cmd.start_fdiv), .numer(f_num), .denom(odr),
      .done(fdiv_done), .quot(fq), .remain(fr));

   logic [16:0] f_ff;
   logic        fdone_ff;
   always_ff @(posedge clock) begin
      if (reset || cmd.start_sqrt) begin
         fdone_ff <= 1'b0;
      end else if (sqrt_done && f_direct) begin
         fdone_ff <= 1'b1;
      end else if (fdiv_done) begin
         fdone_ff <= 1'b1;
      end
      if (sqrt_done && f_direct) begin
         f_ff <= f_direct_val;
      end else if (fdiv_done) begin
         f_ff <= fq[16:0];
      end
   end

   // ---------------- projections p = round(dot*d/|d|^2) ----------------
   logic [63:0] pnx, pny, pqx, pqy;
   logic [41:0] prx, pry;
   logic        pdx_done, pdy_done, pdone_ff;
   logic [59:0] dmx, dmy;
   logic [38:0] adot;
   logic [20:0] adx, ady;

   assign adot = dot_ff[38] ? 39'(-dot_ff) : 39'(dot_ff);
   assign adx = ddx_ff[20] ? 21'(-ddx_ff) : 21'(ddx_ff);
   assign ady = ddy_ff[20] ? 21'(-ddy_ff) : 21'(ddy_ff);
   assign dmx = 60'(adot) * 60'(adx);
   assign dmy = 60'(adot) * 60'(ady);
   assign pnx = {4'd0, dmx};
   assign pny = {4'd0, dmy};

   ocvl_divider #(.NumWidth(64), .DenWidth(42)) u_div_px (
      .clock, .reset, .start(cmd.start_pdiv), .numer(pnx), .denom(sq_ff),
      .done(pdx_done), .quot(pqx), .remain(prx));
   ocvl_divider #(.NumWidth(64), .DenWidth(42)) u_div_py (
      .clock, .reset, .start(cmd.start_pdiv), .numer(pny), .denom(sq_ff),
      .done(pdy_done), .quot(pqy), .remain(pry));

   logic [40:0] px_mag_ff, py_mag_ff;
   always_ff @(posedge clock) begin
      if (reset || cmd.start_pdiv) begin
         pdone_ff <= 1'b0;
      end else if (pdx_done) begin
         pdone_ff <= 1'b1;
      end
      if (pdx_done) begin
         px_mag_ff <= 41'(pqx) + (({prx, 1'b0} >= {1'b0, sq_ff}) ? 41'd1 : 41'd0);
         py_mag_ff <= 41'(pqy) + (({pry, 1'b0} >= {1'b0, sq_ff}) ? 41'd1 : 41'd0);
      end
   end

   // ---------------- apply: out = v - round(f*p/2^16), saturate ----------------
   function automatic logic signed [15:0] limit(input logic signed [15:0] v,
                                                input logic [40:0] pm,
                                                input logic neg,
                                                input logic [16:0] f);
      logic [57:0] prod;
      logic [42:0] red;
      logic signed [44:0] res;
      prod = 58'(pm) * 58'(f);
      red = 43'((prod + 58'd32768) >> 16);
      res = 45'(v) - (neg ? -$signed({2'b0, red}) : $signed({2'b0, red}));
      if (res > 45'sd32767) begin
         return 16'sh7fff;
      end
      if (res < -45'sd32768) begin
         return 16'sh8000;
      end
      return 16'(res);
   endfunction

   logic signed [15:0] olx_ff, oly_ff;
   logic [12:0]        hits_ff;
   logic               seen_out_ff;
   logic signed [19:0] ocx_ff, ocy_ff, ocz_ff;
   logic signed [15:0] olz_ff, oax_ff, oay_ff, oaz_ff;
   logic               negx, negy;

   assign negx = dot_ff[38] ^ ddx_ff[20];
   assign negy = dot_ff[38] ^ ddy_ff[20];

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (cmd.do_apply) begin
            olx_ff <= limit(vx_ff, px_mag_ff, negx, f_ff);
            oly_ff <= limit(vy_ff, py_mag_ff, negy, f_ff);
         end else begin
            olx_ff <= vx_ff;
            oly_ff <= vy_ff;
         end
         olz_ff <= vz_ff;
         oax_ff <= wx_ff;
         oay_ff <= wy_ff;
         oaz_ff <= wz_ff;
         ocx_ff <= cx_ff;
         ocy_ff <= cy_ff;
         ocz_ff <= cz_ff;
         seen_out_ff <= seen_ff;
         hits_ff <= 13'(tally_ff);
      end
   end

   always_comb begin
      status = '0;
      status.div_done = div_done_ff | dx_done | dy_done | dz_done;
      status.seen = seen_ff;
      status.dot_pos = dot_pos_ff;
      status.sqrt_done = sqrt_done;
      status.f_direct = f_direct;
      status.fdiv_done = fdone_ff;
      status.pdiv_done = pdone_ff;
   end

   assign out_lin_x = olx_ff;
   assign out_lin_y = oly_ff;
   assign out_lin_z = olz_ff;
   assign out_ang_x = oax_ff;
   assign out_ang_y = oay_ff;
   assign out_ang_z = oaz_ff;
   assign centroid_x = ocx_ff;
   assign centroid_y = ocy_ff;
   assign centroid_z = ocz_ff;
   assign obstacle_seen = seen_out_ff;
   assign hit_count = hits_ff;
endmodule

/* src/obstacle_centroid_velocity_limiter_top.sv */
// Top level: obstacle centroid velocity limiter.
//
//   channel  dir  carries
//   req      in   scan point (cmd 0) or end of scan with desired twist (cmd 1)
//   rsp      out  limited twist, centroid, seen flag, hit count
//   csr      in   register writes, index 0..4
//
// Scan points are taken one per cycle, while the sequencer is idle, and accumulated.
// An end item's response ends one of four paths: no obstacle, velocity not toward it,
// factor 0 or 1, or factor divided out. The work is a 32-step centroid divide, a 32-step
// square root with the 64-step projection divides beside it,
// then a 64-step factor divide only when the factor lies strictly between 0 and 1.
// No request is taken from an end item until its response transfers.
// Reset clears accumulators, registers to defaults and the sequencer.
module obstacle_centroid_velocity_limiter_top #(
   parameter int MaxPoints = ocvl_pkg::MaxPointsDefault
) (
   input  logic                                     clock,
   input  logic                                     reset,
   ocvl_req_if.sink                                 req,
   ocvl_rsp_if.source                               rsp,
   input  logic                                     csr_write_enable,
   input  logic [ocvl_pkg::CsrIndexWidth-1:0]       csr_index,
   input  logic [ocvl_pkg::CsrDataWidth-1:0]        csr_write_data
);
   import ocvl_pkg::*;

   logic [13:0] od_ff, sd_ff, hl_ff, hw_ff;
   logic        if_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         od_ff <= 14'd2048;
         sd_ff <= 14'd205;
         if_ff <= 1'b0;
         hl_ff <= 14'd1966;
         hw_ff <= 14'd1638;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_OBSTACLE_DISTANCE:  od_ff <= csr_write_data;
            CSR_SELF_DETECT_MARGIN: sd_ff <= csr_write_data;
            CSR_IGNORE_FRONT:       if_ff <= csr_write_data[0];
            CSR_HALF_LENGTH:        hl_ff <= csr_write_data;
            CSR_HALF_WIDTH:         hw_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   cmd_type    cmd;
   status_type status;
   logic       busy, take, point_take, end_take, rsp_take;

   assign req.ready = !busy;
   assign take = req.valid && req.ready;
   assign point_take = take && !req.cmd;
   assign end_take = take && req.cmd;
   assign rsp_take = rsp.valid && rsp.ready;

   ocvl_ctrl u_ctrl (
      .clock, .reset, .end_take, .rsp_take, .status, .cmd, .busy, .rsp_valid(rsp.valid));

   ocvl_datapath #(.MaxPoints(MaxPoints)) u_dp (
      .clock, .reset, .point_take, .end_take, .cmd, .status,
      .obstacle_distance(od_ff), .self_detect_margin(sd_ff), .ignore_front(if_ff),
      .half_length(hl_ff), .half_width(hw_ff),
      .point_x(req.point_x), .point_y(req.point_y), .point_z(req.point_z),
      .want_lin_x(req.want_lin_x), .want_lin_y(req.want_lin_y), .want_lin_z(req.want_lin_z),
      .want_ang_x(req.want_ang_x), .want_ang_y(req.want_ang_y), .want_ang_z(req.want_ang_z),
      .out_lin_x(rsp.out_lin_x), .out_lin_y(rsp.out_lin_y), .out_lin_z(rsp.out_lin_z),
      .out_ang_x(rsp.out_ang_x), .out_ang_y(rsp.out_ang_y), .out_ang_z(rsp.out_ang_z),
      .centroid_x(rsp.centroid_x), .centroid_y(rsp.centroid_y), .centroid_z(rsp.centroid_z),
      .obstacle_seen(rsp.obstacle_seen), .hit_count(rsp.hit_count));

   // No request transfer while a response is pending.
   assert property (@(posedge clock) disable iff (reset) rsp.valid |-> !req.ready)
      else $error("request taken while response pending");
   // An end item always starts the sequencer.
   assert property (@(posedge clock) disable iff (reset) end_take |=> busy)
      else $error("end item did not start sequencer");
   // No obstacle is reported from a scan without hits.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp.valid && rsp.hit_count == 13'd0) |-> !rsp.obstacle_seen)
      else $error("obstacle seen with no hits");
endmodule

/* tb/obstacle_centroid_velocity_limiter_top_tb.sv */
// Testbench for the obstacle centroid velocity limiter: directed and random scans checked against a predictor.
module obstacle_centroid_velocity_limiter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ocvl_pkg::*;

   localparam int MaxHits = 4096;
   localparam int StallLimit = 6000;
   localparam int SettleCycles = 300;
   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED = CSR_HALF_WIDTH + 3'd1;

   typedef struct {
      logic cmd;
      logic signed [19:0] px, py, pz;
      logic signed [15:0] vx, vy, vz, wx, wy, wz;
   } scan_item_t;

   typedef struct packed {
      logic signed [15:0] lin_x, lin_y, lin_z, ang_x, ang_y, ang_z;
      logic signed [19:0] cen_x, cen_y, cen_z;
      logic seen;
      logic [12:0] hits;
   } twist_t;

   // Scoreboard: mirrors the limiter and holds the commands still due
   class limiter_scoreboard;
      longint od = 2048, sd = 205, hl = 1966, hw = 1638;
      bit front_off = 0;
      longint acc_x, acc_y, acc_z;
      int tally;
      twist_t due[$];
      int mismatches, scans, limited, full_scans;

      function longint round_div(longint n, longint d);
         if (n >= 0) return (n + d / 2) / d;
         return -((-n + d / 2) / d);
      endfunction

      function longint root(longint unsigned v);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return longint'(res);
      endfunction

      function longint sat(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function longint onto_box(longint c, longint h);
         longint a;
         a = (c < 0) ? -c : c;
         if (a > h) a = h;
         return (c < 0) ? -a : a;
      endfunction

      function void write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] val);
         case (idx)
            CSR_OBSTACLE_DISTANCE: od = val;
            CSR_SELF_DETECT_MARGIN: sd = val;
            CSR_IGNORE_FRONT: front_off = val[0];
            CSR_HALF_LENGTH: hl = val;
            CSR_HALF_WIDTH: hw = val;
            default: ;
         endcase
      endfunction

      function void note_input(scan_item_t it);
         longint x, y, ax, ay, cx, cy, cz, cn, dx, dy, dt, sq, f, r, odr, ox, oy;
         bit hit;
         twist_t t;
         if (!it.cmd) begin
            x = it.px;
            y = it.py;
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            hit = ax < hl + od && ay < hw + od && (ax > hl + sd || ay > hw + sd) &&
                  (!front_off || x < hl);
            if (hit && tally < MaxHits) begin
               acc_x += x;
               acc_y += y;
               acc_z += it.pz;
               tally++;
            end
            return;
         end
         cx = 0; cy = 0; cz = 0;
         if (tally > 0) begin
            cx = round_div(acc_x, tally);
            cy = round_div(acc_y, tally);
            cz = round_div(acc_z, tally);
         end
         cn = cx * cx + cy * cy + cz * cz;
         t.seen = (cn * 10000) > (64'sd1 << 24);
         ox = it.vx;
         oy = it.vy;
         // remove the velocity part that points from the box toward the centroid
         if (t.seen) begin
            dx = cx - onto_box(cx, hl);
            dy = cy - onto_box(cy, hw);
            dt = longint'(it.vx) * dx + longint'(it.vy) * dy;
            if (dt > 0) begin
               sq = dx * dx + dy * dy;
               if (od == 0) begin
                  f = 65536;
               end else begin
                  r = root(longint'(sq) << 16);
                  odr = od << 8;
                  if (r >= odr) f = 0;
                  else if (2 * r <= odr) f = 65536;
                  else f = ((odr - r) << 17) / odr;
               end
               ox = sat(it.vx - round_div(f * round_div(dt * dx, sq), 65536));
               oy = sat(it.vy - round_div(f * round_div(dt * dy, sq), 65536));
               limited++;
            end
         end
         t.lin_x = ox; t.lin_y = oy; t.lin_z = it.vz;
         t.ang_x = it.wx; t.ang_y = it.wy; t.ang_z = it.wz;
         t.cen_x = cx; t.cen_y = cy; t.cen_z = cz;
         t.hits = tally;
         if (tally == MaxHits) full_scans++;
         scans++;
         due.push_back(t);
         acc_x = 0; acc_y = 0; acc_z = 0;
         tally = 0;
      endfunction

      function void check_result(twist_t got);
         twist_t e;
         if (due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: response with nothing expected");
            return;
         end
         e = due.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: lin %0d %0d %0d ang %0d %0d %0d cen %0d %0d %0d seen %0d hits %0d",
                        got.lin_x, got.lin_y, got.lin_z, got.ang_x, got.ang_y, got.ang_z,
                        got.cen_x, got.cen_y, got.cen_z, got.seen, got.hits,
                        "\n   expected lin %0d %0d %0d ang %0d %0d %0d cen %0d %0d %0d",
                        e.lin_x, e.lin_y, e.lin_z, e.ang_x, e.ang_y, e.ang_z,
                        e.cen_x, e.cen_y, e.cen_z, " seen %0d hits %0d", e.seen, e.hits);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_write_data = '0;
   ocvl_req_if req();
   ocvl_rsp_if rsp();

   limiter_scoreboard board = new();
   int send_idle_pct, recv_stall_pct, quiet;
   int sent;

   obstacle_centroid_velocity_limiter_top DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   // Receiver: stall at random on the falling edge
   always @(negedge clock) begin
      rsp.ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Monitor: note every transfer at the rising edge
   always @(posedge clock) begin
      twist_t got;
      scan_item_t it;
      quiet++;
      if (!reset && req.valid && req.ready) begin
         it.cmd = req.cmd;
         it.px = req.point_x; it.py = req.point_y; it.pz = req.point_z;
         it.vx = req.want_lin_x; it.vy = req.want_lin_y; it.vz = req.want_lin_z;
         it.wx = req.want_ang_x; it.wy = req.want_ang_y; it.wz = req.want_ang_z;
         board.note_input(it);
         quiet = 0;
      end
      if (!reset && rsp.valid && rsp.ready) begin
         got.lin_x = rsp.out_lin_x; got.lin_y = rsp.out_lin_y; got.lin_z = rsp.out_lin_z;
         got.ang_x = rsp.out_ang_x; got.ang_y = rsp.out_ang_y; got.ang_z = rsp.out_ang_z;
         got.cen_x = rsp.centroid_x; got.cen_y = rsp.centroid_y;
         got.cen_z = rsp.centroid_z;
         got.seen = rsp.obstacle_seen;
         got.hits = rsp.hit_count;
         board.check_result(got);
         quiet = 0;
      end
      if (quiet >= StallLimit) begin
         $display("watchdog: no transfer for %0d cycles", StallLimit);
         $display("obstacle_centroid_velocity_limiter_top_tb NOT OK");
         $finish;
      end
   end

   task automatic send(scan_item_t it);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req.cmd = it.cmd;
      req.point_x = it.px; req.point_y = it.py; req.point_z = it.pz;
      req.want_lin_x = it.vx; req.want_lin_y = it.vy; req.want_lin_z = it.vz;
      req.want_ang_x = it.wx; req.want_ang_y = it.wy; req.want_ang_z = it.wz;
      req.valid = 1;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      sent++;
   endtask

   task automatic point(longint x, longint y, longint z);
      scan_item_t it;
      it.cmd = 0;
      it.px = x; it.py = y; it.pz = z;
      it.vx = $urandom; it.vy = $urandom; it.vz = $urandom;
      it.wx = $urandom; it.wy = $urandom; it.wz = $urandom;
      send(it);
   endtask

   task automatic scan_end(longint vx, longint vy, longint vz);
      scan_item_t it;
      it.cmd = 1;
      it.px = $urandom; it.py = $urandom; it.pz = $urandom;
      it.vx = vx; it.vy = vy; it.vz = vz;
      it.wx = $urandom; it.wy = $urandom; it.wz = $urandom;
      send(it);
   endtask

   // Hold off until every command has come back and the block has settled
   task automatic drain();
      req.valid = 0;
      while (board.due.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] val);
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = val;
      @(negedge clock);
      csr_write_enable = 0;
      board.write_reg(idx, val);
      quiet = 0;
   endtask

   task automatic configure(int od, int sd, int fr, int hl, int hw);
      drain();
      write_csr(CSR_OBSTACLE_DISTANCE, od);
      write_csr(CSR_SELF_DETECT_MARGIN, sd);
      write_csr(CSR_IGNORE_FRONT, fr);
      write_csr(CSR_HALF_LENGTH, hl);
      write_csr(CSR_HALF_WIDTH, hw);
   endtask

   function automatic longint coord(longint h);
      longint m;
      if ($urandom_range(0, 9) == 0) return $signed(20'($urandom));
      m = $urandom_range(0, int'(h + board.od + 8));
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   function automatic longint vel();
      if ($urandom_range(0, 3) == 0) return $signed(16'($urandom));
      return $signed(16'($urandom_range(0, 8191))) - 4096;
   endfunction

   // One well-formed scan: points around the band, then the end item
   task automatic random_scan();
      int n;
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 30);
      repeat (n) begin
         point(coord(board.hl), coord(board.hw),
               $urandom_range(0, 5) == 0 ? $signed(20'($urandom)) :
               longint'($urandom_range(0, 8000)) - 4000);
      end
      scan_end(vel(), vel(), vel());
   endtask

   initial begin
      int hl, hw;
      req.valid = 0;
      req.cmd = 0;
      req.point_x = 0; req.point_y = 0; req.point_z = 0;
      req.want_lin_x = 0; req.want_lin_y = 0; req.want_lin_z = 0;
      req.want_ang_x = 0; req.want_ang_y = 0; req.want_ang_z = 0;
      rsp.ready = 0;
      send_idle_pct = 24;
      recv_stall_pct = 60;
      quiet = 0;
      sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: band edges at reset defaults, extremes of every field
      hl = 1966; hw = 1638;
      scan_end(100, -100, 7);
      point(hl + 206, 0, 0);
      point(hl + 205, 0, 0);
      point(-(hl + 2047), 5, -524288);
      point(hl + 2048, 0, 0);
      point(0, hw + 2047, 524287);
      point(0, -(hw + 300), 0);
      point(-524288, 524287, 0);
      scan_end(32767, 0, -32768);
      point(hl + 1500, 0, 100);
      point(hl + 1500, 10, -100);
      scan_end(-32768, 32767, 32767);
      point(hl + 500, hw + 500, 0);
      scan_end(32767, 32767, 0);
      point(-(hl + 900), -(hw + 900), 0);
      scan_end(-32768, -32768, 1);
      scan_end(0, 0, 0);

      // Configuration sweep, extremes first, then random settings
      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 3) begin send_idle_pct = 60; recv_stall_pct = 24; end
         if (ph == 6) begin send_idle_pct = 0; recv_stall_pct = 0; end
         case (ph)
            0: configure(2048, 205, 1, 1966, 1638);
            1: configure(16383, 0, 0, 0, 0);
            2: configure(0, 100, 0, 1000, 1000);
            3: configure(16383, 16383, 1, 16383, 16383);
            4: begin
               configure(3000, 10, 0, 500, 8000);
               write_csr(CSR_UNUSED, $urandom);
            end
            default: configure($urandom_range(1, 6000), $urandom_range(0, 400),
                               $urandom_range(0, 1), $urandom_range(0, 4000),
                               $urandom_range(0, 4000));
         endcase
         while (sent < 25 + (ph + 1) * 115) random_scan();
      end

      drain();
      $display("covered %0d scans, %0d with limited velocity, %0d with full tally",
               board.scans, board.limited, board.full_scans);
      if (board.mismatches == 0 && board.due.size() == 0) begin
         $display("obstacle_centroid_velocity_limiter_top_tb OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", board.mismatches, board.due.size());
         $display("obstacle_centroid_velocity_limiter_top_tb NOT OK");
      end
      $finish;
   end
endmodule
